// File: design/bemc_pkg.sv
// Shared types and codes for the block extent map cache.
package bemc_pkg;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] disk;
    logic [31:0] size;
    logic        hole;
  } entry_t;

  typedef struct packed {
    logic   pop;
    logic   push;
    entry_t push_entry;
  } qctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_PFIN,
    ST_PRES,
    ST_A,
    ST_NEW,
    ST_TAIL,
    ST_B,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam logic CMD_PROBE  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [1:0] STAT_HIT  = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_INS  = 2'd2;
  localparam logic [1:0] STAT_REJ  = 2'd3;

endpackage

// File: design/block_extent_map_cache_core.sv
// Top level of the block extent map cache: run table chain and sequencer.
//
//  channel  | direction | tdata (low bit up)                  | tuser (low bit up)
//  s_axis   | in        | file_block, length, disk_block      | command, hole
//  m_axis   | out       | hit_disk_block, block_count         | status[1:0], hit_hole
//
// A probe makes one pass over the run table; an insert makes two, a counting pass and a rewrite pass.
// An insert rejected for overflow stops after its counting pass.
// Each step moves the table chain one run past its head cell, one run per cycle.
// A zero-length or out-of-range insert is rejected straight from idle, with no pass over the table.
// Reset empties the table at once; no clearing pass.
// One item at a time; a result waits in the output register while m_axis stalls.
module block_extent_map_cache_core #(
  parameter int MAX_RUNS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // file_block, length, disk_block
  input  logic [1:0]  s_axis_tuser,   // command, hole
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // hit_disk_block, block_count
  output logic [2:0]  m_axis_tuser    // status[1:0], hit_hole
);
  import bemc_pkg::*;

  localparam int D  = MAX_RUNS + 2;
  localparam int IW = $clog2(D);
  localparam int OW = $clog2(D + 1);

  entry_t          cell_q [D];
  entry_t          nbr    [D];
  qctl_t           qctl;
  logic [OW-1:0]   occ_q, occ_d;
  logic [OW-1:0]   wpos;
  logic [IW-1:0]   wi;

  assign wpos  = occ_q - OW'(qctl.pop);
  assign wi    = wpos[IW-1:0];
  assign occ_d = occ_q + OW'(qctl.push) - OW'(qctl.pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_cell
    if (k < D - 1) begin : g_mid
      assign nbr[k] = cell_q[k+1];
    end else begin : g_last
      assign nbr[k] = cell_q[k];
    end
    bemc_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (qctl.pop),
      .load_i      (qctl.push && (wi == IW'(k))),
      .nbr_i       (nbr[k]),
      .load_data_i (qctl.push_entry),
      .q_o         (cell_q[k])
    );
  end

  bemc_ctrl #(
    .MAX_RUNS (MAX_RUNS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser[0]),
    .fb_i        (s_axis_tdata[31:0]),
    .len_i       (s_axis_tdata[63:32]),
    .disk_i      (s_axis_tdata[95:64]),
    .hole_i      (s_axis_tuser[1]),
    .head_i      (cell_q[0]),
    .qctl_o      (qctl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (m_axis_tuser[1:0]),
    .disk_o      (m_axis_tdata[31:0]),
    .hole_o      (m_axis_tuser[2]),
    .count_o     (m_axis_tdata[63:32])
  );

endmodule

// File: design/bemc_cell.sv
// One cell of the run table chain: holds one run, shifts toward the head.
module bemc_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic             load_i,
  input  bemc_pkg::entry_t nbr_i,
  input  bemc_pkg::entry_t load_data_i,
  output bemc_pkg::entry_t q_o
);
  import bemc_pkg::*;

  entry_t run_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= load_data_i;
    end else if (shift_i) begin
      run_q <= nbr_i;
    end
  end

  assign q_o = run_q;

endmodule

// File: design/bemc_ctrl.sv
// Sequencer for the run table: probe scan, two-pass insert with trim, split and merge.
module bemc_ctrl #(
  parameter int MAX_RUNS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [31:0]      fb_i,
  input  logic [31:0]      len_i,
  input  logic [31:0]      disk_i,
  input  logic             hole_i,
  input  bemc_pkg::entry_t head_i,
  output bemc_pkg::qctl_t  qctl_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      disk_o,
  output logic             hole_o,
  output logic [31:0]      count_o
);
  import bemc_pkg::*;

  localparam int RCW = $clog2(MAX_RUNS + 1);
  localparam int NCW = $clog2(MAX_RUNS + 4);

  typedef struct packed {
    logic [31:0] fb;
    logic [31:0] len;
    logic [31:0] disk;
    logic [31:0] fin;
    logic        hole;
    entry_t      pend;
    logic [31:0] pend_e;
    logic [31:0] pend_de;
    entry_t      tail;
    entry_t      cand;
    logic [31:0] cand_e;
    logic [31:0] nxt_s;
    logic [31:0] rest;
    logic [31:0] gap;
    logic [1:0]  res_status;
    logic [31:0] res_disk;
    logic        res_hole;
    logic [31:0] res_count;
    logic [1:0]  out_status;
    logic [31:0] out_disk;
    logic        out_hole;
    logic [31:0] out_count;
  } wrk_t;

  state_e           state_q, state_d;
  wrk_t             w_q, w_d;
  logic             pass_q, pass_d;
  logic [RCW-1:0]   idx_q, idx_d;
  logic [RCW-1:0]   run_count_q, run_count_d;
  logic [NCW-1:0]   ncnt_q, ncnt_d;
  logic             pend_v_q, pend_v_d;
  logic             tail_v_q, tail_v_d;
  logic             after_new_q, after_new_d;
  logic             cand_v_q, cand_v_d;
  logic             nxt_v_q, nxt_v_d;
  logic             hit_q, hit_d;
  logic             out_v_q, out_v_d;

  logic [32:0] sum;
  logic [32:0] head_end;
  logic        rem;
  logic [31:0] trim_d;
  logic [31:0] trim_n;
  logic        e_go, e_merge, e_h, fol;
  logic [31:0] e_s, e_d, e_n, e_end, e_dm;

  assign sum      = {1'b0, fb_i} + {1'b0, len_i};
  assign head_end = {1'b0, head_i.start} + {1'b0, head_i.size};
  assign rem      = (idx_q != run_count_q);
  assign trim_d   = head_i.hole ? 32'd0 : (head_i.disk + w_q.fin - head_i.start);
  assign trim_n   = head_end[31:0] - w_q.fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      idx_q       <= '0;
      run_count_q <= '0;
      ncnt_q      <= '0;
      pend_v_q    <= 1'b0;
      tail_v_q    <= 1'b0;
      after_new_q <= 1'b0;
      cand_v_q    <= 1'b0;
      nxt_v_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      idx_q       <= idx_d;
      run_count_q <= run_count_d;
      ncnt_q      <= ncnt_d;
      pend_v_q    <= pend_v_d;
      tail_v_q    <= tail_v_d;
      after_new_q <= after_new_d;
      cand_v_q    <= cand_v_d;
      nxt_v_q     <= nxt_v_d;
      hit_q       <= hit_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    pass_d      = pass_q;
    idx_d       = idx_q;
    run_count_d = run_count_q;
    ncnt_d      = ncnt_q;
    pend_v_d    = pend_v_q;
    tail_v_d    = tail_v_q;
    after_new_d = after_new_q;
    cand_v_d    = cand_v_q;
    nxt_v_d     = nxt_v_q;
    hit_d       = hit_q;
    out_v_d     = out_v_q;
    qctl_o      = '0;
    in_ready_o  = 1'b0;
    e_go        = 1'b0;
    e_merge     = 1'b0;
    e_s         = '0;
    e_d         = '0;
    e_n         = '0;
    e_h         = 1'b0;
    e_end       = '0;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          w_d.fb   = fb_i;
          w_d.len  = len_i;
          w_d.disk = disk_i;
          w_d.hole = hole_i;
          w_d.fin  = sum[31:0];
          idx_d    = '0;
          if (cmd_i == CMD_PROBE) begin
            cand_v_d = 1'b0;
            nxt_v_d  = 1'b0;
            state_d  = ST_PROBE;
          end else if (len_i == 32'd0 || sum[32]) begin
            w_d.res_status = STAT_REJ;
            w_d.res_disk   = '0;
            w_d.res_hole   = 1'b0;
            w_d.res_count  = '0;
            state_d        = ST_OUT;
          end else begin
            pass_d   = 1'b0;
            ncnt_d   = '0;
            pend_v_d = 1'b0;
            tail_v_d = 1'b0;
            state_d  = ST_A;
          end
        end
      end
      ST_PROBE: begin
        if (rem) begin
          qctl_o.pop        = 1'b1;
          qctl_o.push       = 1'b1;
          qctl_o.push_entry = head_i;
          idx_d             = idx_q + RCW'(1);
          if (head_i.start <= w_q.fb) begin
            w_d.cand   = head_i;
            w_d.cand_e = head_end[31:0];
            cand_v_d   = 1'b1;
          end else if (!nxt_v_q) begin
            w_d.nxt_s = head_i.start;
            nxt_v_d   = 1'b1;
          end
        end else begin
          state_d = ST_PFIN;
        end
      end
      ST_PFIN: begin
        hit_d        = cand_v_q && (w_q.cand_e > w_q.fb);
        w_d.rest     = w_q.cand_e - w_q.fb;
        w_d.res_disk = w_q.cand.hole ? 32'd0 : (w_q.cand.disk + w_q.fb - w_q.cand.start);
        w_d.gap      = w_q.nxt_s - w_q.fb;
        state_d      = ST_PRES;
      end
      ST_PRES: begin
        if (hit_q) begin
          w_d.res_status = STAT_HIT;
          w_d.res_hole   = w_q.cand.hole;
          w_d.res_count  = (w_q.rest < w_q.len) ? w_q.rest : w_q.len;
        end else begin
          w_d.res_status = STAT_MISS;
          w_d.res_disk   = '0;
          w_d.res_hole   = 1'b0;
          w_d.res_count  = (nxt_v_q && (w_q.gap < w_q.len)) ? w_q.gap : w_q.len;
        end
        state_d = ST_OUT;
      end
      ST_A: begin
        if (rem && (head_i.start < w_q.fb)) begin
          qctl_o.pop = 1'b1;
          if (!pass_q) begin
            qctl_o.push       = 1'b1;
            qctl_o.push_entry = head_i;
          end
          idx_d   = idx_q + RCW'(1);
          e_go    = 1'b1;
          e_s     = head_i.start;
          e_d     = head_i.disk;
          e_h     = head_i.hole;
          if (head_end > {1'b0, w_q.fb}) begin
            e_n   = w_q.fb - head_i.start;
            e_end = w_q.fb;
          end else begin
            e_n   = head_i.size;
            e_end = head_end[31:0];
          end
          if (head_end > {1'b0, w_q.fin}) begin
            tail_v_d       = 1'b1;
            w_d.tail.start = w_q.fin;
            w_d.tail.disk  = trim_d;
            w_d.tail.size  = trim_n;
            w_d.tail.hole  = head_i.hole;
          end
        end else begin
          state_d = ST_NEW;
        end
      end
      ST_NEW: begin
        e_go        = 1'b1;
        e_merge     = 1'b1;
        e_s         = w_q.fb;
        e_d         = w_q.disk;
        e_n         = w_q.len;
        e_h         = w_q.hole;
        e_end       = w_q.fin;
        after_new_d = 1'b1;
        state_d     = tail_v_q ? ST_TAIL : ST_B;
      end
      ST_TAIL: begin
        e_go        = 1'b1;
        e_merge     = 1'b1;
        e_s         = w_q.tail.start;
        e_d         = w_q.tail.disk;
        e_n         = w_q.tail.size;
        e_h         = w_q.tail.hole;
        e_end       = w_q.tail.start + w_q.tail.size;
        after_new_d = 1'b0;
        state_d     = ST_B;
      end
      ST_B: begin
        if (rem) begin
          qctl_o.pop = 1'b1;
          if (!pass_q) begin
            qctl_o.push       = 1'b1;
            qctl_o.push_entry = head_i;
          end
          idx_d = idx_q + RCW'(1);
          if (head_end > {1'b0, w_q.fin}) begin
            e_go        = 1'b1;
            e_merge     = after_new_q;
            after_new_d = 1'b0;
            e_h         = head_i.hole;
            e_end       = head_end[31:0];
            if (head_i.start < w_q.fin) begin
              e_s = w_q.fin;
              e_d = trim_d;
              e_n = trim_n;
            end else begin
              e_s = head_i.start;
              e_d = head_i.disk;
              e_n = head_i.size;
            end
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!pass_q) begin
          if (ncnt_q > NCW'(MAX_RUNS)) begin
            w_d.res_status = STAT_REJ;
            w_d.res_disk   = '0;
            w_d.res_hole   = 1'b0;
            w_d.res_count  = '0;
            state_d        = ST_OUT;
          end else begin
            pass_d   = 1'b1;
            idx_d    = '0;
            ncnt_d   = '0;
            pend_v_d = 1'b0;
            tail_v_d = 1'b0;
            state_d  = ST_A;
          end
        end else begin
          qctl_o.push       = 1'b1;
          qctl_o.push_entry = w_q.pend;
          run_count_d       = RCW'(ncnt_q);
          w_d.res_status    = STAT_INS;
          w_d.res_disk      = '0;
          w_d.res_hole      = 1'b0;
          w_d.res_count     = '0;
          state_d           = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_v_q || out_ready_i) begin
          w_d.out_status = w_q.res_status;
          w_d.out_disk   = w_q.res_disk;
          w_d.out_hole   = w_q.res_hole;
          w_d.out_count  = w_q.res_count;
          out_v_d        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // merge into the pending run or retire it and start a new one
    fol  = pend_v_q && (w_q.pend_e == e_s) &&
           ((w_q.pend.hole || e_h) ? (w_q.pend.hole && e_h) : (w_q.pend_de == e_d));
    e_dm = e_h ? 32'd0 : e_d;
    if (e_go) begin
      if (e_merge && fol) begin
        w_d.pend.size = w_q.pend.size + e_n;
        w_d.pend_e    = e_end;
        w_d.pend_de   = w_q.pend_de + e_n;
      end else begin
        if (pend_v_q && pass_q) begin
          qctl_o.push       = 1'b1;
          qctl_o.push_entry = w_q.pend;
        end
        w_d.pend.start = e_s;
        w_d.pend.disk  = e_dm;
        w_d.pend.size  = e_n;
        w_d.pend.hole  = e_h;
        w_d.pend_e     = e_end;
        w_d.pend_de    = e_dm + e_n;
        pend_v_d       = 1'b1;
        ncnt_d         = ncnt_q + NCW'(1);
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = w_q.out_status;
  assign disk_o      = w_q.out_disk;
  assign hole_o      = w_q.out_hole;
  assign count_o     = w_q.out_count;

endmodule

// File: design/bemc_chk.sv
// Port-level checks for the block extent map cache top level.
module bemc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import bemc_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_insert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] == STAT_INS || m_axis_tuser[1:0] == STAT_REJ)
      |-> m_axis_tdata == 64'd0 && !m_axis_tuser[2])
    else $error("insert result carries probe data");

  a_no_disk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] == STAT_MISS || m_axis_tuser[2])
      |-> m_axis_tdata[31:0] == 32'd0)
    else $error("disk block on miss or hole");

endmodule

bind block_extent_map_cache_core bemc_chk u_bemc_chk (.*);
